[hdl/rgb_conv3x3_zero_pad_top_macros.svh]
// Assertion helpers for the RGB 3x3 convolution block.
// Both macros sample on aclk and stand down while aresetn is low.
`ifndef RGB_CONV3X3_ZERO_PAD_TOP_MACROS_SVH
`define RGB_CONV3X3_ZERO_PAD_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RCZ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcz: same-cycle check failed");
// Next-cycle implication.
`define RCZ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcz: next-cycle check failed");
`else
`define RCZ_ASSERT_IMP(name, ante, cons)
`define RCZ_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[hdl/rcz_pkg.sv]
`timescale 1ns / 1ps

package rcz_pkg;

    localparam int PIX_W          = 8;
    localparam int CH_N           = 3;
    localparam int ROWS           = 3;
    localparam int WIN_COLS       = 3;
    localparam int TAP_W          = 16;
    localparam int COEF_FRAC_BITS = 8;

    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int COEF_W     = TAP_W * WIN_COLS;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // pixel (unsigned, widened by a sign bit) times a signed tap
    localparam int PROD_W   = PIX_W + 1 + TAP_W;
    localparam int COLSUM_W = PROD_W + 2;
    localparam int SUM_W    = COLSUM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MID     = 3'd3,
        CFG_COEF_BOT     = 3'd4
    } cfg_index_t;

    typedef logic [PIX_W-1:0] chan_t;

    // red in the low bits
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgb_t;

    // index 0 is the row above, 2 the row below
    typedef rgb_t [ROWS-1:0] column_t;

    typedef logic signed [TAP_W-1:0] tap_t;
    typedef tap_t [ROWS-1:0] tap_col_t;

    typedef logic signed [COLSUM_W-1:0] colsum_t;
    typedef colsum_t [CH_N-1:0] colsum_vec_t;

    typedef struct packed {
        logic  kind;
        chan_t pix_red;
        chan_t pix_green;
        chan_t pix_blue;
    } in_word_t;

    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        logic  frame_end;
    } out_word_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic row_top_ok;
        logic row_bot_ok;
        logic col_left_ok;
        logic col_right_ok;
    } win_ctl_t;

    typedef struct packed {
        logic [ROWS-1:0] row_ok;
        logic            col_ok;
    } cell_mask_t;

    // negative gives 0, drop the fraction, saturate at full scale
    function automatic chan_t finish_channel(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] shifted;
        shifted = sum >>> COEF_FRAC_BITS;
        if (sum[SUM_W-1]) begin
            return '0;
        end else if (|shifted[SUM_W-1:PIX_W]) begin
            return '1;
        end else begin
            return shifted[PIX_W-1:0];
        end
    endfunction

endpackage

[hdl/rgb_conv3x3_zero_pad_top.sv]
`timescale 1ns / 1ps
// RGB 3x3 convolution with zero padding, one shared kernel for all channels.
// Input channel s_*: one raster-order word per pixel (kind 0), or a drain
// word (kind 1) that pushes out the last row once all rows are in. A drain
// word that arrives before the frame is complete is taken and dropped.
// Result channel m_*: filtered, clamped 8-bit channels; frame_end marks the
// last result of the frame, after which the next pixel opens a new frame.
// Each result belongs to the pixel one row and one pixel behind the word
// that completes its neighbourhood (width + 1 words earlier in the stream).
// The result passes stage 1 (line buffer read), the window cells, the
// column sums and the output register. Throughput: one word per cycle
// unless m_ready stalls, set by one read and one write per cycle per RAM.
// The config port (cfg_wr_en, cfg_index, cfg_wr_data) writes a register
// at any edge; write it only while the pipeline is empty.
// Reset: 640 x 480, identity kernel, counters and window cleared. The line
// buffers are not cleared; entries from before the first row are masked.
// Back-pressure: when m_ready is low the output register holds its word and
// the pipeline keeps filling its empty stages, then s_ready falls.
`include "rgb_conv3x3_zero_pad_top_macros.svh"

module rgb_conv3x3_zero_pad_top import rcz_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = (ADDR_W > IMG_W_W) ? ADDR_W : IMG_W_W;
    localparam int ROW_W  = IMG_H_W + 1;
    localparam int W_MAX  = (1 << IMG_W_W) - 1;
    localparam int W_CAP  = (MAX_WIDTH < W_MAX) ? MAX_WIDTH : W_MAX;
    localparam int RGB_W  = $bits(rgb_t);

    localparam logic [IMG_W_W-1:0] W_CAP_V     = IMG_W_W'(W_CAP);
    localparam logic [COEF_W-1:0]  COEF_MID_RST = COEF_W'(1 << (TAP_W + COEF_FRAC_BITS));

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [COEF_W-1:0]  coef_top_reg;
    logic [COEF_W-1:0]  coef_mid_reg;
    logic [COEF_W-1:0]  coef_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMG_W_W'(640);
            image_height_reg <= IMG_H_W'(480);
            coef_top_reg     <= '0;
            coef_mid_reg     <= COEF_MID_RST;
            coef_bot_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[IMG_H_W-1:0];
                CFG_COEF_TOP:     coef_top_reg     <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_MID:     coef_mid_reg     <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_BOT:     coef_bot_reg     <= cfg_wr_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry: a zero dimension counts as one, width is capped
    // at the line buffer depth.
    logic [IMG_W_W-1:0] w_eff;
    logic [IMG_H_W-1:0] h_eff;

    assign w_eff = (image_width_reg == '0) ? IMG_W_W'(1) :
                   ((image_width_reg > W_CAP_V) ? W_CAP_V : image_width_reg);
    assign h_eff = (image_height_reg == '0) ? IMG_H_W'(1) : image_height_reg;

    // ---------------------------------------------------------------------
    // Stage handshakes: each stage takes a word when empty or when its
    // occupant moves on in the same cycle.
    // ---------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !m_valid_reg || m_ready;
    assign s3_ready = !v3_reg || s4_ready;
    assign s2_ready = !v2_reg || s3_ready;
    assign s1_ready = !v1_reg || s2_ready;
    assign s_ready  = s1_ready;

    // ---------------------------------------------------------------------
    // Input stage: position counters, border flags, line buffer access
    // ---------------------------------------------------------------------
    logic [ADDR_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]   in_row_reg,  in_row_next;
    logic [ADDR_W-1:0]  out_col_reg, out_col_next;
    logic [IMG_H_W-1:0] out_row_reg, out_row_next;

    logic [CNT_W-1:0]   w_x, in_col_x, col_c_x, col_inc_x;
    logic [CNT_W-1:0]   out_col_x, oc_x, oc_inc_x;
    logic [ADDR_W-1:0]  col_c;
    logic               col_wrap, row_full, drain, ignore, acc;
    logic [ROW_W-1:0]   h_x;
    logic [IMG_H_W-1:0] orow;
    logic [IMG_H_W:0]   orow_inc;
    logic               oc_last, orow_last;
    rgb_t               pix_s0;
    win_ctl_t           ctl_s0;

    always_comb begin
        w_x       = CNT_W'(w_eff);
        h_x       = ROW_W'(h_eff);
        in_col_x  = CNT_W'(in_col_reg);
        col_c_x   = (in_col_x < w_x) ? in_col_x : (w_x - CNT_W'(1));
        col_c     = col_c_x[ADDR_W-1:0];
        col_inc_x = col_c_x + CNT_W'(1);
        col_wrap  = col_inc_x >= w_x;

        // once every row is in, any word drains; an early drain is dropped
        row_full = in_row_reg >= h_x;
        drain    = s_data.kind || row_full;
        ignore   = s_data.kind && !row_full;
        acc      = s_valid && s_ready && !ignore;

        pix_s0 = drain ? '0 : rgb_t'{blue:  s_data.pix_blue,
                                     green: s_data.pix_green,
                                     red:   s_data.pix_red};

        out_col_x = CNT_W'(out_col_reg);
        oc_x      = (out_col_x < w_x) ? out_col_x : (w_x - CNT_W'(1));
        oc_inc_x  = oc_x + CNT_W'(1);
        oc_last   = oc_inc_x >= w_x;
        orow      = (out_row_reg < h_eff) ? out_row_reg : (h_eff - IMG_H_W'(1));
        orow_inc  = {1'b0, orow} + (IMG_H_W+1)'(1);
        orow_last = orow_inc >= {1'b0, h_eff};

        ctl_s0.emit         = (in_row_reg >= ROW_W'(2)) ||
                              ((in_row_reg == ROW_W'(1)) && (col_c_x >= CNT_W'(1)));
        ctl_s0.last         = orow_last && oc_last;
        ctl_s0.row_top_ok   = orow != '0;
        ctl_s0.row_bot_ok   = !orow_last;
        ctl_s0.col_left_ok  = oc_x != '0;
        ctl_s0.col_right_ok = !oc_last;

        // advance the input position
        in_col_next = col_wrap ? '0 : col_inc_x[ADDR_W-1:0];
        in_row_next = col_wrap ? (in_row_reg + ROW_W'(1)) : in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (ctl_s0.emit) begin
            if (ctl_s0.last) begin
                // frame done: restart every counter
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (oc_last) begin
                out_col_next = '0;
                out_row_next = orow_inc[IMG_H_W-1:0];
            end else begin
                out_col_next = oc_inc_x[ADDR_W-1:0];
                out_row_next = orow;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (acc) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------------------------------------------------------------
    // Line buffers. The middle line is swapped in place at acceptance; the
    // upper line takes the old middle entry when the word leaves stage 1.
    // ---------------------------------------------------------------------
    logic [RGB_W-1:0]  mid_rd, up_rd;
    logic              up_we;
    logic [ADDR_W-1:0] col1_reg;

    rcz_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_mid_line (
        .clk     (aclk),
        .wr_en   (acc),
        .wr_addr (col_c),
        .wr_data (pix_s0),
        .rd_en   (acc),
        .rd_addr (col_c),
        .rd_data (mid_rd)
    );

    rcz_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_up_line (
        .clk     (aclk),
        .wr_en   (up_we),
        .wr_addr (col1_reg),
        .wr_data (mid_rd),
        .rd_en   (acc),
        .rd_addr (col_c),
        .rd_data (up_rd)
    );

    // ---------------------------------------------------------------------
    // Stage 1: line buffer data arrives
    // ---------------------------------------------------------------------
    rgb_t             pix1_reg;
    win_ctl_t         ctl1_reg;
    logic             byp1_reg;
    logic [RGB_W-1:0] bypd1_reg;
    logic             shift_en;
    column_t          col_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s1_ready) begin
            v1_reg <= acc;
        end
    end

    // The word leaving stage 1 writes the upper line in the same edge that
    // the next word reads it; catch that same-address case here.
    always_ff @(posedge aclk) begin
        if (acc) begin
            pix1_reg  <= pix_s0;
            col1_reg  <= col_c;
            ctl1_reg  <= ctl_s0;
            byp1_reg  <= v1_reg && (col1_reg == col_c);
            bypd1_reg <= mid_rd;
        end
    end

    assign shift_en = v1_reg && s2_ready;
    assign up_we    = shift_en;

    always_comb begin
        col_new[0] = byp1_reg ? rgb_t'(bypd1_reg) : rgb_t'(up_rd);
        col_new[1] = rgb_t'(mid_rd);
        col_new[2] = pix1_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 2: the window, a chain of three column cells. Words that yield
    // no result still shift the window but go no further.
    // ---------------------------------------------------------------------
    win_ctl_t    ctl2_reg;
    logic        calc_en;
    column_t     col_chain  [WIN_COLS+1];
    tap_col_t    cell_taps  [WIN_COLS];
    cell_mask_t  cell_mask  [WIN_COLS];
    colsum_vec_t cell_psum  [WIN_COLS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (s2_ready) begin
            v2_reg <= v1_reg && ctl1_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            ctl2_reg <= ctl1_reg;
        end
    end

    assign calc_en             = v2_reg && s3_ready;
    assign col_chain[WIN_COLS] = col_new;

    for (genvar k = 0; k < WIN_COLS; k++) begin : g_col
        assign cell_taps[k][0] = coef_top_reg[k*TAP_W +: TAP_W];
        assign cell_taps[k][1] = coef_mid_reg[k*TAP_W +: TAP_W];
        assign cell_taps[k][2] = coef_bot_reg[k*TAP_W +: TAP_W];

        assign cell_mask[k] = cell_mask_t'{
            row_ok: {ctl2_reg.row_bot_ok, 1'b1, ctl2_reg.row_top_ok},
            col_ok: (k == 0) ? ctl2_reg.col_left_ok :
                    ((k == WIN_COLS - 1) ? ctl2_reg.col_right_ok : 1'b1)
        };

        rcz_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .col_in   (col_chain[k+1]),
            .col_out  (col_chain[k]),
            .calc_en  (calc_en),
            .taps     (cell_taps[k]),
            .mask     (cell_mask[k]),
            .psum     (cell_psum[k])
        );
    end

    // ---------------------------------------------------------------------
    // Stage 3: column sums held in the cells; add, clamp, load the output
    // ---------------------------------------------------------------------
    win_ctl_t                ctl3_reg;
    logic signed [SUM_W-1:0] chan_sum [CH_N];
    out_word_t               m_data_reg, m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (s3_ready) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_en) begin
            ctl3_reg <= ctl2_reg;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            chan_sum[ch] = '0;
            for (int k = 0; k < WIN_COLS; k++) begin
                chan_sum[ch] = chan_sum[ch] + SUM_W'($signed(cell_psum[k][ch]));
            end
        end
        m_data_next.out_red   = finish_channel(chan_sum[0]);
        m_data_next.out_green = finish_channel(chan_sum[1]);
        m_data_next.out_blue  = finish_channel(chan_sum[2]);
        m_data_next.frame_end = ctl3_reg.last;
    end

    // Output register: hold the word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && s4_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // input stalls only when a result is held at the output
    `RCZ_ASSERT_IMP(a_stall_from_output, !s_ready, m_valid && !m_ready)
    // a drain word before the frame is complete enters nothing
    `RCZ_ASSERT_NEXT(a_early_drain_dropped, s_valid && s_ready && s_data.kind && (in_row_reg < ROW_W'(h_eff)), !v1_reg)
    // the frame's last result restarts all position counters
    `RCZ_ASSERT_NEXT(a_frame_end_restart, acc && ctl_s0.emit && ctl_s0.last, (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0))

endmodule

[hdl/rcz_ram.sv]
`timescale 1ns / 1ps

module rcz_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rcz_cell.sv]
`timescale 1ns / 1ps

module rcz_cell import rcz_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  column_t     col_in,
    output column_t     col_out,
    input  logic        calc_en,
    input  tap_col_t    taps,
    input  cell_mask_t  mask,
    output colsum_vec_t psum
);

    column_t     col_reg;
    colsum_vec_t psum_reg;
    colsum_vec_t psum_next;

    logic signed [TAP_W-1:0]    tap_eff;
    logic [PIX_W-1:0]           px;
    logic signed [PROD_W-1:0]   prod;
    logic signed [COLSUM_W-1:0] acc;

    // hold one window column, hand it to the left neighbour on a shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    // weight the column with this position's taps; drop rows and columns outside the frame
    always_comb begin
        tap_eff = '0;
        px      = '0;
        prod    = '0;
        acc     = '0;
        for (int ch = 0; ch < CH_N; ch++) begin
            acc = '0;
            for (int r = 0; r < ROWS; r++) begin
                tap_eff = (mask.row_ok[r] && mask.col_ok) ? $signed(taps[r]) : '0;
                px      = col_reg[r][ch*PIX_W +: PIX_W];
                prod    = $signed({1'b0, px}) * tap_eff;
                acc     = acc + COLSUM_W'(prod);
            end
            psum_next[ch] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_en) begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule
